// ===== sv/mclc_pkg.sv =====
// Shared types and constants for the motor current limiter chain.
// No dependencies; every other file in sv/ imports this package.
package mclc_pkg;

  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;
  localparam int PERCENT_SCALE   = 100;
  localparam int SPEED_BAND      = 140;
  localparam int TEMP_LIMIT      = 70;
  localparam int VOLT_SCALE      = 10;
  localparam int TOT_W           = 11;   // elapsed plus leftover always fits
  localparam int STEP_W          = 11;
  localparam int DIV_N_W         = 18;   // bits of (total * 100)
  localparam int PROD_W          = 15;   // band offset times current, at most 28000
  localparam int BAND_OFF_W      = 9;    // band offset, 0 to 280
  localparam int SPEED_DIV_SHIFT = 24;   // reciprocal of 280 for 15-bit dividends
  localparam int SPEED_DIV_MULT  = 59919;
  localparam int SPEED_DIV_W     = 16;

  localparam logic [6:0] CUR_FULL    = 7'd100;
  localparam logic [9:0] ELAPSED_MAX = 10'd1000;

  typedef enum logic [1:0] {
    REG_SPEED_EN,
    REG_SPEED_LIM,
    REG_LOW_CUTOFF
  } reg_idx_t;

  typedef enum logic [1:0] {
    SPD_OFF,
    SPD_BELOW,
    SPD_BAND,
    SPD_ABOVE
  } spd_mode_t;

  typedef struct packed {
    logic        speed_en;
    logic [14:0] speed_lim;
    logic [6:0]  low_cutoff;
  } cfg_t;

  typedef struct packed {
    logic [6:0]        req;
    logic [9:0]        elapsed;
    logic [14:0]       speed;
    logic signed [7:0] temp;
    logic [9:0]        volts;
    logic              brake;
    logic              shift;
  } in_t;

  typedef struct packed {
    logic [6:0]        cur;
    logic [PROD_W-1:0] prod;
    spd_mode_t         mode;
    logic [9:0]        elapsed;
    logic              thermal;
    logic              undervolt;
    logic              brake;
    logic              shift;
  } mid_t;

  typedef struct packed {
    logic [6:0] cur;
    logic       enable;
    logic       speed_lim;
    logic       thermal;
  } res_t;

endpackage

// ===== sv/mclc_cfg.sv =====
// APB-style configuration registers of the current limiter.
// Depends on mclc_pkg (cfg_t, reg_idx_t, widths).
module mclc_cfg import mclc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_SPEED_EN:   cfg.speed_en   <= pwdata[0];
        REG_SPEED_LIM:  cfg.speed_lim  <= pwdata[14:0];
        REG_LOW_CUTOFF: cfg.low_cutoff <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPEED_EN:   prdata = {{(DATA_W-1){1'b0}}, cfg.speed_en};
      REG_SPEED_LIM:  prdata = {{(DATA_W-15){1'b0}}, cfg.speed_lim};
      REG_LOW_CUTOFF: prdata = {{(DATA_W-7){1'b0}}, cfg.low_cutoff};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== sv/mclc_speed.sv =====
// Front stage: input clamps, speed band classification and band product.
// Depends on mclc_pkg (in_t, cfg_t, mid_t, constants).
module mclc_speed import mclc_pkg::*; (
  input  logic clk,
  input  logic load,
  input  in_t  item,
  input  cfg_t cfg,
  output mid_t mid
);

  mid_t                   mid_next;
  logic [6:0]             cur;
  logic signed [16:0]     spd;
  logic signed [16:0]     lo;
  logic signed [16:0]     hi;
  logic signed [16:0]     off;
  logic [BAND_OFF_W-1:0]  off_b;
  logic [15:0]            prod16;
  logic [10:0]            cut10;

  always_comb begin
    cur    = (item.req > CUR_FULL) ? CUR_FULL : item.req;
    spd    = $signed({2'b00, item.speed});
    lo     = $signed({2'b00, cfg.speed_lim}) - $signed(17'(SPEED_BAND));
    hi     = $signed({2'b00, cfg.speed_lim}) + $signed(17'(SPEED_BAND));
    off    = spd - lo;
    off_b  = off[BAND_OFF_W-1:0];
    prod16 = {7'd0, off_b} * {9'd0, cur};
    cut10  = 11'(cfg.low_cutoff) * 11'(VOLT_SCALE);

    mid_next.cur     = cur;
    mid_next.prod    = prod16[PROD_W-1:0];
    mid_next.elapsed = (item.elapsed > ELAPSED_MAX) ? ELAPSED_MAX : item.elapsed;
    // strictly above 70 C, signed compare
    mid_next.thermal   = (item.temp > $signed(8'(TEMP_LIMIT)));
    // floor(v/10) < c is the same as v < 10*c
    mid_next.undervolt = ({1'b0, item.volts} < cut10);
    mid_next.brake     = item.brake;
    mid_next.shift     = item.shift;

    if (!cfg.speed_en || cfg.speed_lim == '0) begin
      mid_next.mode = SPD_OFF;
    end else if (spd < lo) begin
      mid_next.mode = SPD_BELOW;
    end else if (spd > hi) begin
      mid_next.mode = SPD_ABOVE;
    end else begin
      mid_next.mode = SPD_BAND;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid <= mid_next;
    end
  end

endmodule

// ===== sv/mclc_limit.sv =====
// Stateful stage: band division, thermal halving, ramp-up and derating,
// plus the limiter state and the result register. Depends on mclc_pkg.
module mclc_limit import mclc_pkg::*; #(
  parameter int RAMP_TIME_MS   = 3000,
  parameter int DERATE_TIME_MS = 10000
) (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  mid_t mid,
  output res_t res
);

  // Exact floor(100*t / T) as t * K >> S, valid for 100*t below 2^DIV_N_W.
  localparam int R_STEP  = RAMP_TIME_MS / PERCENT_SCALE;
  localparam int R_SHIFT = DIV_N_W + $clog2(RAMP_TIME_MS);
  localparam longint unsigned R_MULT =
    PERCENT_SCALE * (((64'd1 << R_SHIFT) + RAMP_TIME_MS - 1) / RAMP_TIME_MS);
  localparam int R_MULT_W = $clog2(R_MULT + 1);
  localparam int R_PROD_W = TOT_W + R_MULT_W;
  localparam int R_LEFT_W = (RAMP_TIME_MS % PERCENT_SCALE == 0) ?
                            ((R_STEP > 1) ? $clog2(R_STEP) : 1) : TOT_W;

  localparam int D_STEP  = DERATE_TIME_MS / PERCENT_SCALE;
  localparam int D_SHIFT = DIV_N_W + $clog2(DERATE_TIME_MS);
  localparam longint unsigned D_MULT =
    PERCENT_SCALE * (((64'd1 << D_SHIFT) + DERATE_TIME_MS - 1) / DERATE_TIME_MS);
  localparam int D_MULT_W = $clog2(D_MULT + 1);
  localparam int D_PROD_W = TOT_W + D_MULT_W;
  localparam int D_LEFT_W = (DERATE_TIME_MS % PERCENT_SCALE == 0) ?
                            ((D_STEP > 1) ? $clog2(D_STEP) : 1) : TOT_W;

  // limiter state
  logic [6:0]          ramp_last;
  logic [R_LEFT_W-1:0] ramp_left;
  logic [6:0]          derate_pct;
  logic [D_LEFT_W-1:0] derate_left;
  logic                speed_flag;

  logic [6:0]          ramp_last_next;
  logic [R_LEFT_W-1:0] ramp_left_next;
  logic [6:0]          derate_pct_next;
  logic [D_LEFT_W-1:0] derate_left_next;
  logic                speed_flag_next;
  res_t                res_next;

  logic [PROD_W+SPEED_DIV_W-1:0] drop_full;
  logic [6:0]          drop;
  logic [6:0]          cur_spd;
  logic [6:0]          cur_th;
  logic [TOT_W-1:0]    tot_r;
  logic [R_PROD_W-1:0] prod_r;
  logic [STEP_W-1:0]   steps_r;
  logic [TOT_W-1:0]    left_r;
  logic [STEP_W:0]     cap_r;
  logic [6:0]          cur_r;
  logic [TOT_W-1:0]    tot_d;
  logic [D_PROD_W-1:0] prod_d;
  logic [STEP_W-1:0]   steps_d;
  logic [TOT_W-1:0]    left_d;
  logic [6:0]          pct_after;
  logic [6:0]          cur_d;

  always_comb begin
    // linear drop across the band: offset * cur / 280
    drop_full = (PROD_W+SPEED_DIV_W)'(mid.prod) *
                (PROD_W+SPEED_DIV_W)'(SPEED_DIV_MULT);
    drop      = 7'(drop_full >> SPEED_DIV_SHIFT);

    case (mid.mode)
      SPD_OFF:   cur_spd = mid.cur;
      SPD_BELOW: cur_spd = mid.cur;
      SPD_BAND:  cur_spd = mid.cur - drop;
      SPD_ABOVE: cur_spd = '0;
      default:   cur_spd = mid.cur;
    endcase

    case (mid.mode)
      SPD_OFF:   speed_flag_next = speed_flag;
      SPD_BELOW: speed_flag_next = 1'b0;
      default:   speed_flag_next = 1'b1;
    endcase

    cur_th = mid.thermal ? (cur_spd >> 1) : cur_spd;

    // ramp-up: one percent per RAMP_TIME_MS/100, leftover time carried on
    tot_r   = TOT_W'(mid.elapsed) + TOT_W'(ramp_left);
    prod_r  = R_PROD_W'(tot_r) * R_PROD_W'(R_MULT);
    steps_r = STEP_W'(prod_r >> R_SHIFT);
    left_r  = tot_r - TOT_W'(TOT_W'(steps_r) * TOT_W'(R_STEP));
    cap_r   = (STEP_W+1)'(ramp_last) + (STEP_W+1)'(steps_r);
    cur_r   = ((STEP_W+1)'(cur_th) > cap_r) ? cap_r[6:0] : cur_th;
    ramp_left_next = R_LEFT_W'(left_r);

    // low-voltage derating; skipped entirely at zero current
    tot_d   = TOT_W'(mid.elapsed) + TOT_W'(derate_left);
    prod_d  = D_PROD_W'(tot_d) * D_PROD_W'(D_MULT);
    steps_d = STEP_W'(prod_d >> D_SHIFT);
    left_d  = tot_d - TOT_W'(TOT_W'(steps_d) * TOT_W'(D_STEP));

    if (!mid.undervolt) begin
      pct_after = derate_pct;
    end else if (STEP_W'(derate_pct) > steps_d) begin
      pct_after = derate_pct - steps_d[6:0];
    end else begin
      pct_after = '0;
    end

    if (cur_r != '0) begin
      derate_pct_next  = pct_after;
      derate_left_next = mid.undervolt ? D_LEFT_W'(left_d) : '0;
      cur_d            = (cur_r > pct_after) ? pct_after : cur_r;
    end else begin
      derate_pct_next  = derate_pct;
      derate_left_next = derate_left;
      cur_d            = cur_r;
    end

    // brake clears the ramp; shift only gates the motor
    if (mid.brake) begin
      ramp_last_next = '0;
    end else if (mid.shift) begin
      ramp_last_next = cur_r;
    end else if (cur_d == '0) begin
      ramp_last_next = '0;
    end else begin
      ramp_last_next = cur_r;
    end

    res_next.cur       = cur_d;
    res_next.enable    = !mid.brake && !mid.shift && (cur_d != '0);
    res_next.speed_lim = speed_flag_next;
    res_next.thermal   = mid.thermal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_last   <= '0;
      ramp_left   <= '0;
      derate_pct  <= CUR_FULL;
      derate_left <= '0;
      speed_flag  <= 1'b0;
    end else if (load) begin
      ramp_last   <= ramp_last_next;
      ramp_left   <= ramp_left_next;
      derate_pct  <= derate_pct_next;
      derate_left <= derate_left_next;
      speed_flag  <= speed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  // derating ceiling only ever goes down until reset
  a_derate_monotonic: assert property (@(posedge clk) disable iff (rst)
    derate_pct <= $past(derate_pct))
    else $error("derate ceiling increased");

  a_ramp_left_bound: assert property (@(posedge clk) disable iff (rst)
    (RAMP_TIME_MS % PERCENT_SCALE != 0) || (TOT_W'(ramp_left) < TOT_W'(R_STEP)))
    else $error("ramp leftover time out of range");

  a_enable_nonzero: assert property (@(posedge clk) disable iff (rst)
    load |=> (!res.enable || res.cur != '0))
    else $error("motor enabled at zero current");

  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    load |=> (res.cur <= CUR_FULL))
    else $error("limited current above full scale");

  a_brake_clears_ramp: assert property (@(posedge clk) disable iff (rst)
    (load && mid.brake) |=> (ramp_last == '0 && !res.enable))
    else $error("brake did not clear the ramp");

endmodule

// ===== sv/motor_current_limiter_chain.sv =====
// Top level of the motor current limiter chain: handshake pipeline,
// input register and instances. Depends on mclc_pkg, mclc_cfg, mclc_speed, mclc_limit.

// The block takes one control tick per item and returns one result item per tick,
// in order. It accepts a new item in every clock cycle as long as the result side
// keeps up. An accepted item is captured in the input register at the accepting
// edge, then in the speed-band register and then in the result register, at
// which point out_valid rises. The rate of one item per cycle
// is set by the limiter stage, where the ramp and derating state (last ramped
// current, leftover milliseconds, derating ceiling, speed limit flag) is read and
// written back in the same cycle so the next tick sees it. A stalled output holds its
// result while the stages behind it fill; ready propagates back through the
// three stage registers. There is no clearing pass after reset. Registers sit on
// an APB-style port at byte addresses 0 (speed sensor enable), 4 (speed limit in
// rpm x10) and 8 (low cutoff in volts); pready is always high. Write them only
// while the block holds no item.
module motor_current_limiter_chain import mclc_pkg::*; #(
  parameter int RAMP_TIME_MS   = 3000,
  parameter int DERATE_TIME_MS = 10000
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // tick input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [6:0]        requested_current,
  input  logic [9:0]        elapsed_ms,
  input  logic [14:0]       wheel_speed_rpm_x10,
  input  logic signed [7:0] motor_temperature,
  input  logic [9:0]        battery_voltage_x10,
  input  logic              brake_active,
  input  logic              shift_active,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        limited_current,
  output logic              motor_on,
  output logic              speed_capped,
  output logic              thermal_limiting
);

  cfg_t cfg;
  in_t  item;
  mid_t mid;
  res_t res;

  // stage occupancy
  logic in_full;
  logic mid_full;
  logic adv_mid;
  logic adv_res;

  assign pready = 1'b1;

  // a stage moves when it holds an item and the stage ahead is free or draining
  assign adv_res  = mid_full && (!out_valid || out_ready);
  assign adv_mid  = in_full && (!mid_full || adv_res);
  assign in_ready = !in_full || adv_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      mid_full  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (!mid_full || adv_res) begin
        mid_full <= in_full;
      end
      if (!out_valid || out_ready) begin
        out_valid <= mid_full;
      end
    end
  end

  // input register, loaded on every accepted item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.req     <= requested_current;
      item.elapsed <= elapsed_ms;
      item.speed   <= wheel_speed_rpm_x10;
      item.temp    <= motor_temperature;
      item.volts   <= battery_voltage_x10;
      item.brake   <= brake_active;
      item.shift   <= shift_active;
    end
  end

  mclc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // clamps, speed band decision and band product
  mclc_speed u_speed (
    .clk  (clk),
    .load (adv_mid),
    .item (item),
    .cfg  (cfg),
    .mid  (mid)
  );

  // stateful limits and result register
  mclc_limit #(
    .RAMP_TIME_MS   (RAMP_TIME_MS),
    .DERATE_TIME_MS (DERATE_TIME_MS)
  ) u_limit (
    .clk  (clk),
    .rst  (rst),
    .load (adv_res),
    .mid  (mid),
    .res  (res)
  );

  assign limited_current  = res.cur;
  assign motor_on         = res.enable;
  assign speed_capped     = res.speed_lim;
  assign thermal_limiting = res.thermal;

endmodule
